// ===== rtl/core/dlfd_pkg.sv =====
// Shared types, codes and segment decode for the multimeter LCD frame decoder.
package dlfd_pkg;

    localparam int unsigned WinDepth = 13;

    localparam logic [3:0] FrameEndTag  = 4'hE;
    localparam logic [3:0] DigitUnknown = 4'd10;

    typedef enum logic [2:0] {
        PFX_NONE  = 3'd0,
        PFX_NANO  = 3'd1,
        PFX_MICRO = 3'd2,
        PFX_MILLI = 3'd3,
        PFX_KILO  = 3'd4,
        PFX_MEGA  = 3'd5
    } t_prefix;

    typedef enum logic [2:0] {
        UNIT_NONE    = 3'd0,
        UNIT_FARAD   = 3'd1,
        UNIT_OHM     = 3'd2,
        UNIT_AMP     = 3'd3,
        UNIT_HERTZ   = 3'd4,
        UNIT_VOLT    = 3'd5,
        UNIT_PERCENT = 3'd6,
        UNIT_CELSIUS = 3'd7
    } t_unit;

    typedef enum logic [2:0] {
        MODE_DC      = 3'd0,
        MODE_AC      = 3'd1,
        MODE_DIODE   = 3'd2,
        MODE_CAP     = 3'd3,
        MODE_OHM     = 3'd4,
        MODE_FREQ    = 3'd5,
        MODE_PERCENT = 3'd6,
        MODE_TEMP    = 3'd7
    } t_mode;

    localparam logic [1:0] RegTempMask = 2'd0;
    localparam logic [3:0] TempMaskReset = 4'd5;

    typedef struct packed {
        logic [3:0] digit_a;
        logic [3:0] digit_b;
        logic [3:0] digit_c;
        logic [3:0] digit_d;
        logic       negative;
        logic       overload;
        logic [1:0] point_pos;
        t_prefix    prefix_code;
        t_unit      unit_code;
        t_mode      mode_code;
        logic       hold;
        logic       auto_range;
    } t_reading;

    // Seven-segment pattern (bit 7 ignored) to digit value.
    function automatic logic [3:0] seg_to_digit(input logic [7:0] pattern);
        logic [3:0] digit;
        digit = DigitUnknown;
        case (pattern[6:0])
            7'h7d: digit = 4'd0;
            7'h05: digit = 4'd1;
            7'h5b: digit = 4'd2;
            7'h1f: digit = 4'd3;
            7'h27: digit = 4'd4;
            7'h3e: digit = 4'd5;
            7'h7e: digit = 4'd6;
            7'h15: digit = 4'd7;
            7'h7f: digit = 4'd8;
            7'h3f: digit = 4'd9;
            default: digit = DigitUnknown;
        endcase
        return digit;
    endfunction

endpackage

// ===== rtl/core/dmm_lcd_frame_decoder.sv =====
// Multimeter LCD frame decoder: 13-byte window, reading decode and output register.
// A reading appears on the output in the cycle after its end-of-frame byte is taken.
// Throughput: one byte per cycle; the window shift and the decode share one register stage.
// Bytes are taken while the output register is empty or being read out.
// Reset (synchronous, active low) clears the window to zero, empties the output
// register and sets the temperature flag mask to 5.
module dmm_lcd_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_digit_a,
    output logic [3:0]  o_digit_b,
    output logic [3:0]  o_digit_c,
    output logic [3:0]  o_digit_d,
    output logic        o_negative,
    output logic        o_overload,
    output logic [1:0]  o_point_pos,
    output logic [2:0]  o_prefix_code,
    output logic [2:0]  o_unit_code,
    output logic [2:0]  o_mode_code,
    output logic        o_hold,
    output logic        o_auto_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]           r_win [dlfd_pkg::WinDepth];
    logic [3:0]           r_temp_mask;
    logic                 r_out_valid;
    dlfd_pkg::t_reading   r_out;
    dlfd_pkg::t_reading   n_out;
    logic                 in_fire;
    logic                 frame_end;
    logic                 ovl;
    logic [7:0]           pat [4];
    logic [3:0]           dig [4];

    assign pready     = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign frame_end  = (i_rx_byte[7:4] == dlfd_pkg::FrameEndTag);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_mask <= dlfd_pkg::TempMaskReset;
        end else if (psel && penable && pwrite && paddr[1] == dlfd_pkg::RegTempMask[0]) begin
            r_temp_mask <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1] == dlfd_pkg::RegTempMask[0]) begin
            prdata[3:0] = r_temp_mask;
        end
    end

    // Decode of window (frame bytes 0..12) plus the current byte (frame byte 13)
    assign ovl = (r_win[3][2:0] == 3'h7) && (r_win[4][3:0] == 4'hd) &&
                 (r_win[5][2:0] == 3'h6) && (r_win[6][3:0] == 4'h8);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pat[i] = {r_win[1 + 2 * i][3:0], r_win[2 + 2 * i][3:0]};
            dig[i] = ovl ? 4'd0 : dlfd_pkg::seg_to_digit(pat[i]);
        end
    end

    always_comb begin
        n_out.digit_a  = dig[0];
        n_out.digit_b  = dig[1];
        n_out.digit_c  = dig[2];
        n_out.digit_d  = dig[3];
        n_out.negative = !ovl && r_win[1][3];
        n_out.overload = ovl;

        if (r_win[3][3])      n_out.point_pos = 2'd1;
        else if (r_win[5][3]) n_out.point_pos = 2'd2;
        else if (r_win[7][3]) n_out.point_pos = 2'd3;
        else                  n_out.point_pos = 2'd0;

        if (r_win[9][2])       n_out.prefix_code = dlfd_pkg::PFX_NANO;
        else if (r_win[9][3])  n_out.prefix_code = dlfd_pkg::PFX_MICRO;
        else if (r_win[10][3]) n_out.prefix_code = dlfd_pkg::PFX_MILLI;
        else if (r_win[9][1])  n_out.prefix_code = dlfd_pkg::PFX_KILO;
        else if (r_win[10][1]) n_out.prefix_code = dlfd_pkg::PFX_MEGA;
        else                   n_out.prefix_code = dlfd_pkg::PFX_NONE;

        if (r_win[9][0])      n_out.mode_code = dlfd_pkg::MODE_DIODE;
        else if (r_win[0][3]) n_out.mode_code = dlfd_pkg::MODE_AC;
        else                  n_out.mode_code = dlfd_pkg::MODE_DC;

        n_out.unit_code = dlfd_pkg::UNIT_NONE;
        if (r_win[11][3]) begin
            n_out.unit_code = dlfd_pkg::UNIT_FARAD;
            n_out.mode_code = dlfd_pkg::MODE_CAP;
        end else if (r_win[11][2]) begin
            n_out.unit_code = dlfd_pkg::UNIT_OHM;
            n_out.mode_code = dlfd_pkg::MODE_OHM;
        end else if (r_win[12][3]) begin
            n_out.unit_code = dlfd_pkg::UNIT_AMP;
        end else if (r_win[12][1]) begin
            n_out.unit_code = dlfd_pkg::UNIT_HERTZ;
            n_out.mode_code = dlfd_pkg::MODE_FREQ;
        end else if (r_win[12][2]) begin
            n_out.unit_code = dlfd_pkg::UNIT_VOLT;
        end else if (r_win[10][2]) begin
            n_out.unit_code = dlfd_pkg::UNIT_PERCENT;
            n_out.mode_code = dlfd_pkg::MODE_PERCENT;
        end else if ((i_rx_byte[3:0] & r_temp_mask) != 4'd0) begin
            n_out.unit_code = dlfd_pkg::UNIT_CELSIUS;
            n_out.mode_code = dlfd_pkg::MODE_TEMP;
        end

        n_out.hold       = r_win[11][0];
        n_out.auto_range = r_win[0][1];
    end

    // Byte window, oldest at index 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dlfd_pkg::WinDepth; k++) begin
                r_win[k] <= '0;
            end
        end else if (in_fire) begin
            for (int k = 0; k < dlfd_pkg::WinDepth - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[dlfd_pkg::WinDepth - 1] <= i_rx_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid && frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && frame_end) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_digit_a     = r_out.digit_a;
    assign o_digit_b     = r_out.digit_b;
    assign o_digit_c     = r_out.digit_c;
    assign o_digit_d     = r_out.digit_d;
    assign o_negative    = r_out.negative;
    assign o_overload    = r_out.overload;
    assign o_point_pos   = r_out.point_pos;
    assign o_prefix_code = r_out.prefix_code;
    assign o_unit_code   = r_out.unit_code;
    assign o_mode_code   = r_out.mode_code;
    assign o_hold        = r_out.hold;
    assign o_auto_range  = r_out.auto_range;

    // An accepted end-of-frame byte always yields a reading next cycle
    a_frame_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && frame_end |=> r_out_valid)
        else $error("end-of-frame item produced no reading");

    // Overload readings carry zero digits and no sign
    a_overload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && o_overload |->
            o_digit_a == 4'd0 && o_digit_b == 4'd0 && o_digit_c == 4'd0 &&
            o_digit_d == 4'd0 && !o_negative)
        else $error("overload reading with nonzero digits or sign");

    // Temperature mode only comes with the Celsius unit
    a_temp_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
            ((o_mode_code == dlfd_pkg::MODE_TEMP) == (o_unit_code == dlfd_pkg::UNIT_CELSIUS)))
        else $error("temperature mode and Celsius unit disagree");

    // A stalled reading is not overwritten by a new byte
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !in_fire)
        else $error("item taken while reading stalled");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multimeter LCD frame decoder.
module testbench;

    typedef logic [13:0][7:0] t_frame;

    localparam int         StallLimit  = 1000;
    localparam int         DrainCycles = 4;
    localparam logic [1:0] MaskAddr    = 2'(4 * dlfd_pkg::RegTempMask);

    // segment pattern of each digit, digit 0 in the low slot
    localparam logic [9:0][6:0] SegOfDigit = {
        7'h3f, 7'h7f, 7'h15, 7'h7e, 7'h3e, 7'h27, 7'h1f, 7'h5b, 7'h05, 7'h7d
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = '0;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_digit_a;
    logic [3:0]  o_digit_b;
    logic [3:0]  o_digit_c;
    logic [3:0]  o_digit_d;
    logic        o_negative;
    logic        o_overload;
    logic [1:0]  o_point_pos;
    logic [2:0]  o_prefix_code;
    logic [2:0]  o_unit_code;
    logic [2:0]  o_mode_code;
    logic        o_hold;
    logic        o_auto_range;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]          pending_bytes[$];
    dlfd_pkg::t_reading  expected_readings[$];
    logic [7:0]          rx_window [13];
    logic [3:0]          temp_mask = dlfd_pkg::TempMaskReset;
    logic                no_idle = 1'b0;
    int                  in_wait = 0;
    int                  out_wait = 0;
    int                  stall_cycles = 0;
    int                  fail_count = 0;

    dmm_lcd_frame_decoder u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_digit_a     (o_digit_a),
        .o_digit_b     (o_digit_b),
        .o_digit_c     (o_digit_c),
        .o_digit_d     (o_digit_d),
        .o_negative    (o_negative),
        .o_overload    (o_overload),
        .o_point_pos   (o_point_pos),
        .o_prefix_code (o_prefix_code),
        .o_unit_code   (o_unit_code),
        .o_mode_code   (o_mode_code),
        .o_hold        (o_hold),
        .o_auto_range  (o_auto_range),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    function automatic logic [3:0] digit_value(input logic [6:0] seg);
        for (int d = 0; d < 10; d++)
            if (SegOfDigit[d] == seg) return 4'(d);
        return dlfd_pkg::DigitUnknown;
    endfunction

    // f[13] is the end-of-frame byte, f[0..12] the window, oldest first
    function automatic dlfd_pkg::t_reading decode_frame(input t_frame f,
                                                        input logic [3:0] mask);
        dlfd_pkg::t_reading rd;
        logic               ovl;
        logic [7:0]         pat;
        logic [3:0]         dig [4];
        rd = '0;
        ovl = (f[3][2:0] == 3'h7) && (f[4][3:0] == 4'hd) &&
              (f[5][2:0] == 3'h6) && (f[6][3:0] == 4'h8);
        for (int d = 0; d < 4; d++) begin
            pat = {f[1 + 2 * d][3:0], f[2 + 2 * d][3:0]};
            dig[d] = ovl ? 4'd0 : digit_value(pat[6:0]);
        end
        rd.digit_a  = dig[0];
        rd.digit_b  = dig[1];
        rd.digit_c  = dig[2];
        rd.digit_d  = dig[3];
        rd.negative = !ovl && f[1][3];
        rd.overload = ovl;

        if (f[3][3])      rd.point_pos = 2'd1;
        else if (f[5][3]) rd.point_pos = 2'd2;
        else if (f[7][3]) rd.point_pos = 2'd3;

        if (f[9][2])       rd.prefix_code = dlfd_pkg::PFX_NANO;
        else if (f[9][3])  rd.prefix_code = dlfd_pkg::PFX_MICRO;
        else if (f[10][3]) rd.prefix_code = dlfd_pkg::PFX_MILLI;
        else if (f[9][1])  rd.prefix_code = dlfd_pkg::PFX_KILO;
        else if (f[10][1]) rd.prefix_code = dlfd_pkg::PFX_MEGA;
        else               rd.prefix_code = dlfd_pkg::PFX_NONE;

        rd.mode_code = f[9][0] ? dlfd_pkg::MODE_DIODE :
                       (f[0][3] ? dlfd_pkg::MODE_AC : dlfd_pkg::MODE_DC);
        rd.unit_code = dlfd_pkg::UNIT_NONE;
        if (f[11][3]) begin
            rd.unit_code = dlfd_pkg::UNIT_FARAD;
            rd.mode_code = dlfd_pkg::MODE_CAP;
        end else if (f[11][2]) begin
            rd.unit_code = dlfd_pkg::UNIT_OHM;
            rd.mode_code = dlfd_pkg::MODE_OHM;
        end else if (f[12][3]) begin
            rd.unit_code = dlfd_pkg::UNIT_AMP;
        end else if (f[12][1]) begin
            rd.unit_code = dlfd_pkg::UNIT_HERTZ;
            rd.mode_code = dlfd_pkg::MODE_FREQ;
        end else if (f[12][2]) begin
            rd.unit_code = dlfd_pkg::UNIT_VOLT;
        end else if (f[10][2]) begin
            rd.unit_code = dlfd_pkg::UNIT_PERCENT;
            rd.mode_code = dlfd_pkg::MODE_PERCENT;
        end else if ((f[13][3:0] & mask) != 4'h0) begin
            rd.unit_code = dlfd_pkg::UNIT_CELSIUS;
            rd.mode_code = dlfd_pkg::MODE_TEMP;
        end

        rd.hold       = f[11][0];
        rd.auto_range = f[0][1];
        return rd;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // half the time a sparse nibble so the later flags in each priority chain get hit
    function automatic logic [3:0] flag_bits();
        if ($urandom_range(0, 1) == 1)
            return ($urandom_range(0, 4) == 4) ? 4'h0 : 4'(1 << $urandom_range(0, 3));
        return 4'($urandom);
    endfunction

    // ovl_kind: 0-1 overload pattern, 2 near miss of it, else plain digits
    function automatic t_frame make_frame(input int ovl_kind);
        t_frame     frm;
        logic [7:0] pat;
        int         idx;
        frm = '0;
        for (int d = 0; d < 4; d++) begin
            if ($urandom_range(0, 9) == 0) pat = 8'($urandom);
            else pat = {1'($urandom), SegOfDigit[$urandom_range(0, 9)]};
            frm[1 + 2 * d][3:0] = pat[7:4];
            frm[2 + 2 * d][3:0] = pat[3:0];
        end
        frm[0][3:0] = flag_bits();
        for (int k = 9; k < 13; k++) frm[k][3:0] = flag_bits();
        frm[13][3:0] = 4'($urandom);
        if (ovl_kind <= 2) begin
            frm[3][2:0] = 3'h7;
            frm[4][3:0] = 4'hd;
            frm[5][2:0] = 3'h6;
            frm[6][3:0] = 4'h8;
        end
        if (ovl_kind == 2) begin
            idx = 3 + $urandom_range(0, 3);
            frm[idx][0] = ~frm[idx][0];
        end
        // position tags 1..14, the last one is the end-of-frame tag
        for (int k = 0; k < 14; k++) frm[k][7:4] = 4'(k + 1);
        return frm;
    endfunction

    task automatic queue_traffic(input int n_bytes);
        t_frame frm;
        int     kind;
        int     first;
        int     n;
        int     pushed;
        pushed = 0;
        while (pushed < n_bytes) begin
            kind = $urandom_range(0, 9);
            if (kind <= 7) begin
                frm = make_frame($urandom_range(0, 15));
                // a frame joined midway leaves stale bytes in the window
                first = (kind == 7) ? $urandom_range(1, 12) : 0;
                for (int k = first; k < 14; k++) pending_bytes.push_back(frm[k]);
                pushed += 14 - first;
            end else if (kind == 8) begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) pending_bytes.push_back(8'($urandom));
                pushed += n;
            end else begin
                pending_bytes.push_back({dlfd_pkg::FrameEndTag, 4'($urandom)});
                pushed++;
            end
        end
    endtask

    task automatic check_temp_mask();
        logic [31:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= MaskAddr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("temp_flag_mask", temp_mask, rd[3:0]);
    endtask

    task automatic write_temp_mask(input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MaskAddr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        temp_mask = value[3:0];
        check_temp_mask();
    endtask

    // sampled mid-cycle so the driver and sink updates of the edge have settled
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // byte source: predicts a reading for every end-of-frame byte it hands over
    always @(posedge clk) begin : drive_bytes
        t_frame frm;
        logic   taken;
        logic   load;
        int     w;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_wait  <= 0;
            for (int k = 0; k < 13; k++) rx_window[k] = 8'h00;
        end else begin
            taken = in_valid && o_in_ready;
            load  = 1'b0;
            if (taken) begin
                if (in_byte[7:4] == dlfd_pkg::FrameEndTag) begin
                    for (int k = 0; k < 13; k++) frm[k] = rx_window[k];
                    frm[13] = in_byte;
                    expected_readings.push_back(decode_frame(frm, temp_mask));
                end
                for (int k = 0; k < 12; k++) rx_window[k] = rx_window[k + 1];
                rx_window[12] = in_byte;
                w = no_idle ? 0 : $urandom_range(0, 6);
                load = (w == 0);
                in_wait <= w;
            end else if (!in_valid) begin
                if (in_wait > 1) in_wait <= in_wait - 1;
                else load = 1'b1;
            end
            if (load && pending_bytes.size() != 0) begin
                in_byte  <= pending_bytes.pop_front();
                in_valid <= 1'b1;
            end else if (load || taken) begin
                in_valid <= 1'b0;
            end
        end
    end

    // reading sink: stalls at random and checks each reading in order
    always @(posedge clk) begin : sink_readings
        dlfd_pkg::t_reading want;
        int                 w;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_wait  <= 0;
        end else if (o_out_valid && out_ready) begin
            if (expected_readings.size() == 0) begin
                $error("reading with none expected");
                fail_count++;
            end else begin
                want = expected_readings.pop_front();
                check_field("digit_a", want.digit_a, o_digit_a);
                check_field("digit_b", want.digit_b, o_digit_b);
                check_field("digit_c", want.digit_c, o_digit_c);
                check_field("digit_d", want.digit_d, o_digit_d);
                check_field("negative", want.negative, o_negative);
                check_field("overload", want.overload, o_overload);
                check_field("point_pos", want.point_pos, o_point_pos);
                check_field("prefix_code", want.prefix_code, o_prefix_code);
                check_field("unit_code", want.unit_code, o_unit_code);
                check_field("mode_code", want.mode_code, o_mode_code);
                check_field("hold", want.hold, o_hold);
                check_field("auto_range", want.auto_range, o_auto_range);
            end
            w = no_idle ? 0 : $urandom_range(0, 6);
            out_ready <= (w == 0);
            out_wait  <= w;
        end else if (!out_ready) begin
            if (out_wait > 1) out_wait <= out_wait - 1;
            else out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_frame      frm;
        logic [31:0] mask_val;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        check_temp_mask();

        // end-of-frame byte on an all-zero window: no digits, no unit, DC
        pending_bytes.push_back({dlfd_pkg::FrameEndTag, 4'h0});
        // out of step: high-nibble-F byte, then an end byte with every user flag
        pending_bytes.push_back(8'hff);
        pending_bytes.push_back({dlfd_pkg::FrameEndTag, 4'hf});
        // overload frame with the minus bit and every flag set at once
        frm = make_frame(0);
        frm[0][3:0] = 4'hf;
        frm[1][3]   = 1'b1;
        for (int k = 9; k < 14; k++) frm[k][3:0] = 4'hf;
        for (int k = 0; k < 14; k++) pending_bytes.push_back(frm[k]);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back({dlfd_pkg::FrameEndTag, 4'h0});
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: mask_val = 32'h0;
                1: mask_val = 32'hf;
                2, 3, 4, 5: mask_val = 32'(1 << (ph - 2));
                default: mask_val = $urandom;
            endcase
            write_temp_mask(mask_val);
            no_idle = (ph % 3 == 1);
            queue_traffic(250);
            wait_idle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
